[design/assert_macros.svh]
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the HSV to RGB converter checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock and ignored during reset.
`define HSV_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("HSV to RGB assertion failed");

// Concurrent assertion that also holds while reset is asserted.
`define HSV_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("HSV to RGB assertion failed");

`endif

[design/hsvrgb_pkg.sv]
// ============================================================================
// hsvrgb_pkg
// Shared constants, sector codes and pipeline control type of the converter.
// ============================================================================
package hsvrgb_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int HUE_W = 16;
	localparam int IN_W  = 18;
	localparam int OUT_W = 8;
	localparam int SEC_W = 3;
	localparam int H6_W  = HUE_W + SEC_W;

	// Sector of the hue circle, one sixth of a turn each.
	localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BM = 3'd4;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

endpackage

[design/hsvrgb_front.sv]
// ============================================================================
// hsvrgb_front
// First stage: clamps saturation and value and splits hue into sector and
// fraction.
// ============================================================================
module hsvrgb_front import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW = (FRAC_BITS + 1 < 17) ? FRAC_BITS + 1 : 17
) (
	input  logic                    clk,
	input  pipe_en_t                pen,
	input  logic [HUE_W-1:0]        hue,
	input  logic signed [IN_W-1:0]  saturation,
	input  logic signed [IN_W-1:0]  brightness,
	output logic [SEC_W-1:0]        sector_s1,
	output logic [HUE_W-1:0]        frac_s1,
	output logic [SW-1:0]           sat_s1,
	output logic [SW-1:0]           val_s1
);

	localparam int RW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
	localparam logic [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

	logic [H6_W-1:0] h6;
	logic [RW-1:0]   sat_ext;
	logic [RW-1:0]   val_ext;
	logic [RW-1:0]   sat_cl;
	logic [RW-1:0]   val_cl;

	always_comb begin
		h6      = H6_W'(hue) * H6_W'(6);
		sat_ext = RW'(saturation[IN_W-2:0]);
		val_ext = RW'(brightness[IN_W-2:0]);
		if (saturation[IN_W-1]) begin
			sat_cl = '0;
		end else if (sat_ext > ONE_R) begin
			sat_cl = ONE_R;
		end else begin
			sat_cl = sat_ext;
		end
		if (brightness[IN_W-1]) begin
			val_cl = '0;
		end else if (val_ext > ONE_R) begin
			val_cl = ONE_R;
		end else begin
			val_cl = val_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			sector_s1 <= h6[H6_W-1:HUE_W];
			frac_s1   <= h6[HUE_W-1:0];
			sat_s1    <= SW'(sat_cl);
			val_s1    <= SW'(val_cl);
		end
	end

endmodule

[design/hsvrgb_mix.sv]
// ============================================================================
// hsvrgb_mix
// Second and third stages: scaled saturation terms, then p, q and t.
// ============================================================================
module hsvrgb_mix import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW = (FRAC_BITS + 1 < 17) ? FRAC_BITS + 1 : 17
) (
	input  logic               clk,
	input  pipe_en_t           pen,
	input  logic [SEC_W-1:0]   sector_s1,
	input  logic [HUE_W-1:0]   frac_s1,
	input  logic [SW-1:0]      sat_s1,
	input  logic [SW-1:0]      val_s1,
	output logic [SEC_W-1:0]   sector_s3,
	output logic [SW-1:0]      val_s3,
	output logic [SW-1:0]      p_s3,
	output logic [SW-1:0]      q_s3,
	output logic [SW-1:0]      t_s3
);

	localparam int OW  = FRAC_BITS + 1;
	localparam int GW  = HUE_W + 1;
	localparam int MW1 = SW + GW;
	localparam int MW2 = SW + OW;
	localparam logic [OW-1:0] ONE_O = OW'(1) << FRAC_BITS;
	localparam logic [GW-1:0] HUE_ONE = GW'(1) << HUE_W;

	logic [GW-1:0]  gfrac;
	logic [MW1-1:0] sf_full;
	logic [MW1-1:0] sg_full;
	logic [SW-1:0]  sf;
	logic [SW-1:0]  sg;

	logic [SEC_W-1:0] sector_s2;
	logic [SW-1:0]    val_s2;
	logic [OW-1:0]    oms_s2;
	logic [OW-1:0]    omsf_s2;
	logic [OW-1:0]    omsg_s2;

	logic [MW2-1:0] p_full;
	logic [MW2-1:0] q_full;
	logic [MW2-1:0] t_full;

	always_comb begin
		gfrac   = HUE_ONE - GW'(frac_s1);
		sf_full = MW1'(sat_s1) * MW1'(frac_s1);
		sg_full = MW1'(sat_s1) * MW1'(gfrac);
		sf      = sf_full[SW+HUE_W-1:HUE_W];
		sg      = sg_full[SW+HUE_W-1:HUE_W];
	end

	always_ff @(posedge clk) begin
		if (pen.en_s2) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			oms_s2    <= ONE_O - OW'(sat_s1);
			omsf_s2   <= ONE_O - OW'(sf);
			omsg_s2   <= ONE_O - OW'(sg);
		end
	end

	always_comb begin
		p_full = MW2'(val_s2) * MW2'(oms_s2);
		q_full = MW2'(val_s2) * MW2'(omsf_s2);
		t_full = MW2'(val_s2) * MW2'(omsg_s2);
	end

	always_ff @(posedge clk) begin
		if (pen.en_s3) begin
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			p_s3      <= p_full[FRAC_BITS+SW-1:FRAC_BITS];
			q_s3      <= q_full[FRAC_BITS+SW-1:FRAC_BITS];
			t_s3      <= t_full[FRAC_BITS+SW-1:FRAC_BITS];
		end
	end

endmodule

[design/hsvrgb_out.sv]
// ============================================================================
// hsvrgb_out
// Fourth stage: routes v, p, q and t to the channels and scales to bytes.
// ============================================================================
module hsvrgb_out import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW = (FRAC_BITS + 1 < 17) ? FRAC_BITS + 1 : 17
) (
	input  logic               clk,
	input  pipe_en_t           pen,
	input  logic [SEC_W-1:0]   sector_s3,
	input  logic [SW-1:0]      val_s3,
	input  logic [SW-1:0]      p_s3,
	input  logic [SW-1:0]      q_s3,
	input  logic [SW-1:0]      t_s3,
	output logic [OUT_W-1:0]   red_s4,
	output logic [OUT_W-1:0]   green_s4,
	output logic [OUT_W-1:0]   blue_s4
);

	localparam int PW = FRAC_BITS + OUT_W + 1;

	logic [SW-1:0] r_x;
	logic [SW-1:0] g_x;
	logic [SW-1:0] b_x;
	logic [PW-1:0] r_p;
	logic [PW-1:0] g_p;
	logic [PW-1:0] b_p;

	always_comb begin
		unique case (sector_s3)
			SEC_RY: begin
				r_x = val_s3; g_x = t_s3;   b_x = p_s3;
			end
			SEC_YG: begin
				r_x = q_s3;   g_x = val_s3; b_x = p_s3;
			end
			SEC_GC: begin
				r_x = p_s3;   g_x = val_s3; b_x = t_s3;
			end
			SEC_CB: begin
				r_x = p_s3;   g_x = q_s3;   b_x = val_s3;
			end
			SEC_BM: begin
				r_x = t_s3;   g_x = p_s3;   b_x = val_s3;
			end
			default: begin
				r_x = val_s3; g_x = p_s3;   b_x = q_s3;
			end
		endcase
		// Multiply by 255 as 256x - x.
		r_p = (PW'(r_x) << OUT_W) - PW'(r_x);
		g_p = (PW'(g_x) << OUT_W) - PW'(g_x);
		b_p = (PW'(b_x) << OUT_W) - PW'(b_x);
	end

	always_ff @(posedge clk) begin
		if (pen.en_s4) begin
			red_s4   <= r_p[FRAC_BITS+OUT_W-1:FRAC_BITS];
			green_s4 <= g_p[FRAC_BITS+OUT_W-1:FRAC_BITS];
			blue_s4  <= b_p[FRAC_BITS+OUT_W-1:FRAC_BITS];
		end
	end

endmodule

[design/hsv_to_rgb.sv]
// ============================================================================
// hsv_to_rgb
// Fixed-point HSV to 8-bit RGB converter, four-stage pipeline.
// ============================================================================
//  Channel  Handshake            Payload
//  in       in_valid, in_stall   hue, saturation, brightness
//  out      out_valid, out_stall red, green, blue
//
// One request is taken per cycle while in_stall is low; each result passes
// through the four register stages, s1 to s4, before it is offered on out.
// The multipliers of stages two and three bound the stage depth.
// Each stage holds while its successor is full and stalled, so bubbles are
// squeezed out and in_stall rises only when all four stages are full.
// Reset clears the stage valid bits only.
// ============================================================================
module hsv_to_rgb import hsvrgb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [HUE_W-1:0]       hue,
	input  logic signed [IN_W-1:0] saturation,
	input  logic signed [IN_W-1:0] brightness,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_W-1:0]       red,
	output logic [OUT_W-1:0]       green,
	output logic [OUT_W-1:0]       blue
);

	localparam int SW = (FRAC_BITS + 1 < 17) ? FRAC_BITS + 1 : 17;

	pipe_en_t pen;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	logic [SEC_W-1:0] sector_s1;
	logic [HUE_W-1:0] frac_s1;
	logic [SW-1:0]    sat_s1;
	logic [SW-1:0]    val_s1;
	logic [SEC_W-1:0] sector_s3;
	logic [SW-1:0]    val_s3;
	logic [SW-1:0]    p_s3;
	logic [SW-1:0]    q_s3;
	logic [SW-1:0]    t_s3;

	always_comb begin
		pen.en_s4 = !valid_s4 || !out_stall;
		pen.en_s3 = !valid_s3 || pen.en_s4;
		pen.en_s2 = !valid_s2 || pen.en_s3;
		pen.en_s1 = !valid_s1 || pen.en_s2;
	end

	assign in_stall  = !pen.en_s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (pen.en_s1) begin
				valid_s1 <= in_valid;
			end
			if (pen.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (pen.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (pen.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	hsvrgb_front #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_front (
		.clk        (clk),
		.pen        (pen),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.sector_s1  (sector_s1),
		.frac_s1    (frac_s1),
		.sat_s1     (sat_s1),
		.val_s1     (val_s1)
	);

	hsvrgb_mix #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_mix (
		.clk       (clk),
		.pen       (pen),
		.sector_s1 (sector_s1),
		.frac_s1   (frac_s1),
		.sat_s1    (sat_s1),
		.val_s1    (val_s1),
		.sector_s3 (sector_s3),
		.val_s3    (val_s3),
		.p_s3      (p_s3),
		.q_s3      (q_s3),
		.t_s3      (t_s3)
	);

	hsvrgb_out #(
		.FRAC_BITS (FRAC_BITS),
		.SW        (SW)
	) u_out (
		.clk       (clk),
		.pen       (pen),
		.sector_s3 (sector_s3),
		.val_s3    (val_s3),
		.p_s3      (p_s3),
		.q_s3      (q_s3),
		.t_s3      (t_s3),
		.red_s4    (red),
		.green_s4  (green),
		.blue_s4   (blue)
	);

endmodule

[design/hsvrgb_checker.sv]
// ============================================================================
// hsvrgb_checker
// Port-level checks of the converter's handshake and pipeline timing.
// ============================================================================
`include "assert_macros.svh"

module hsvrgb_checker import hsvrgb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [OUT_W-1:0] red,
	input logic [OUT_W-1:0] green,
	input logic [OUT_W-1:0] blue
);

	// A stalled result stays offered.
	`HSV_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)

	// A stalled result keeps its value.
	`HSV_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable({red, green, blue}))

	// The input side only stalls when a result is waiting on a stalled output.
	`HSV_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall)

	// With a free output, an accepted request passes through every stage and is then offered on the output.
	`HSV_ASSERT(a_latency, clk, arst_n, in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)

endmodule

bind hsv_to_rgb hsvrgb_checker u_hsvrgb_checker (.*);

[verif/hsv_to_rgb_checker.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches both channels of the HSV to RGB converter, computes the expected
// color of every accepted request in fixed point and compares it with the
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_checker import hsvrgb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [HUE_W-1:0]       hue,
	input  logic signed [IN_W-1:0] saturation,
	input  logic signed [IN_W-1:0] brightness,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [OUT_W-1:0]       red,
	input  logic [OUT_W-1:0]       green,
	input  logic [OUT_W-1:0]       blue,
	output int                     errors,
	output int                     pending,
	output int                     checked
);

	localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS_DEF;
	localparam logic [63:0] TURN = 64'd1 << HUE_W;

	typedef struct packed {
		logic [OUT_W-1:0] r;
		logic [OUT_W-1:0] g;
		logic [OUT_W-1:0] b;
	} rgb_t;

	rgb_t color_q[$];

	function automatic logic [63:0] unit_clamp(input logic [IN_W-1:0] raw);
		if (raw[IN_W-1])
			return 64'd0;
		if ({46'd0, raw} > UNIT)
			return UNIT;
		return {46'd0, raw};
	endfunction

	function automatic logic [OUT_W-1:0] to_channel(input logic [63:0] x);
		logic [63:0] scaled;
		scaled = (x * 64'd255) >> FRAC_BITS_DEF;
		return scaled[OUT_W-1:0];
	endfunction

	function automatic rgb_t hsv_color(input logic [HUE_W-1:0] h,
			input logic [IN_W-1:0] s_raw, input logic [IN_W-1:0] v_raw);
		logic [H6_W-1:0]  h6;
		logic [SEC_W-1:0] sector;
		logic [63:0]      f, s, v, sf, sg, p, q, t, xr, xg, xb;
		rgb_t             c;
		h6 = {{SEC_W{1'b0}}, h} * H6_W'(6);
		sector = h6[H6_W-1:HUE_W];
		f = {48'd0, h6[HUE_W-1:0]};
		s = unit_clamp(s_raw);
		v = unit_clamp(v_raw);
		sf = (s * f) >> HUE_W;
		sg = (s * (TURN - f)) >> HUE_W;
		p = (v * (UNIT - s)) >> FRAC_BITS_DEF;
		q = (v * (UNIT - sf)) >> FRAC_BITS_DEF;
		t = (v * (UNIT - sg)) >> FRAC_BITS_DEF;
		case (sector)
			SEC_RY: begin xr = v; xg = t; xb = p; end
			SEC_YG: begin xr = q; xg = v; xb = p; end
			SEC_GC: begin xr = p; xg = v; xb = t; end
			SEC_CB: begin xr = p; xg = q; xb = v; end
			SEC_BM: begin xr = t; xg = p; xb = v; end
			default: begin xr = v; xg = p; xb = q; end
		endcase
		c.r = to_channel(xr);
		c.g = to_channel(xg);
		c.b = to_channel(xb);
		return c;
	endfunction

	task automatic compare_channel(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (color_q.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, actual %0d %0d %0d",
						$time, red, green, blue);
					errors++;
				end else begin
					want = color_q.pop_front();
					compare_channel("red", want.r, red);
					compare_channel("green", want.g, green);
					compare_channel("blue", want.b, blue);
					checked++;
				end
			end
			if (in_valid && !in_stall)
				color_q.push_back(hsv_color(hue, saturation, brightness));
			pending = color_q.size();
		end
	end

endmodule

[verif/tb_hsv_to_rgb.sv]
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb
// Drives the HSV to RGB converter with directed corner pixels and random
// pixels under four phases of sender idling and receiver stalling; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hsv_to_rgb;
	import hsvrgb_pkg::*;

	localparam int UNIT = 1 << FRAC_BITS_DEF;
	localparam int SIXTH = 10923;
	localparam int PHASE_ITEMS = 170;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [HUE_W-1:0]       hue;
	logic signed [IN_W-1:0] saturation;
	logic signed [IN_W-1:0] brightness;
	logic                   out_valid;
	logic                   out_stall;
	logic [OUT_W-1:0]       red;
	logic [OUT_W-1:0]       green;
	logic [OUT_W-1:0]       blue;

	int errors;
	int pending;
	int checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int directed = 0;

	hsv_to_rgb i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	hsv_to_rgb_checker i_color_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results still outstanding.", pending);
		$display("FAIL hsv_to_rgb");
		$finish;
	end

	task automatic send_pixel(input int h, input int s, input int v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		hue        <= h[HUE_W-1:0];
		saturation <= s[IN_W-1:0];
		brightness <= v[IN_W-1:0];
		do
			@(posedge clk);
		while (in_stall);
		sent++;
	endtask

	function automatic int random_unit();
		case ($urandom_range(9))
			0: return $urandom_range((1 << IN_W) - 1);
			1: return 0;
			2: return UNIT;
			3: return -$urandom_range(1 << (IN_W - 1), 1);
			4: return $urandom_range((1 << (IN_W - 1)) - 1, UNIT + 1);
			default: return $urandom_range(UNIT);
		endcase
	endfunction

	function automatic int random_hue();
		if ($urandom_range(3) == 0)
			return ($urandom_range(5) * SIXTH + $urandom_range(4) - 2) & 16'hFFFF;
		return $urandom_range((1 << HUE_W) - 1);
	endfunction

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		out_stall  <= 1'b0;
		hue        <= '0;
		saturation <= '0;
		brightness <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners of the hue circle, sector edges and clamping of both inputs.
		send_pixel(0, UNIT, UNIT);
		send_pixel(65535, UNIT, UNIT);
		send_pixel(SIXTH - 1, UNIT, UNIT);
		send_pixel(SIXTH, UNIT, UNIT);
		send_pixel(2 * SIXTH - 1, UNIT, UNIT);
		send_pixel(2 * SIXTH, UNIT / 2, UNIT);
		send_pixel(32768, UNIT, UNIT / 2);
		send_pixel(4 * SIXTH - 1, UNIT, UNIT);
		send_pixel(4 * SIXTH, UNIT, UNIT);
		send_pixel(5 * SIXTH - 1, UNIT, UNIT);
		send_pixel(5 * SIXTH, UNIT, UNIT);
		send_pixel(60000, UNIT / 3, UNIT - 1);
		send_pixel(5000, 0, UNIT);
		send_pixel(5000, -1, UNIT);
		send_pixel(20000, -(1 << (IN_W - 1)), UNIT);
		send_pixel(30000, (1 << (IN_W - 1)) - 1, UNIT);
		send_pixel(40000, UNIT + 1, UNIT);
		send_pixel(50000, UNIT, 0);
		send_pixel(50000, UNIT, -1);
		send_pixel(15000, UNIT / 2, -(1 << (IN_W - 1)));
		send_pixel(25000, UNIT / 2, (1 << (IN_W - 1)) - 1);
		send_pixel(35000, UNIT / 2, UNIT + 1);
		send_pixel(45000, 1, 1);
		send_pixel(55000, UNIT - 1, UNIT - 1);
		directed = sent;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(random_hue(), random_unit(), random_unit());
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d pixels (%0d directed, the rest random) and checked %0d results,",
			sent, directed, checked);
		$display("under no pressure, sender gaps, receiver stalls and both together.");
		if (errors == 0 && pending == 0) begin
			$display("PASS hsv_to_rgb");
		end else begin
			$display("FAIL hsv_to_rgb");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/hsvrgb_pkg.sv
design/hsvrgb_front.sv
design/hsvrgb_mix.sv
design/hsvrgb_out.sv
design/hsv_to_rgb.sv
design/hsvrgb_checker.sv
verif/hsv_to_rgb_checker.sv
verif/tb_hsv_to_rgb.sv
